FILE: rtl/core/matrix3x3_inverse_assert.svh
// Assertion macros for the 3x3 matrix inverse block.
// Used by the port checker; needs clk and rst_n in the including scope.
`ifndef MATRIX3X3_INVERSE_ASSERT_SVH
`define MATRIX3X3_INVERSE_ASSERT_SVH

// Check a property while out of reset
`define M3I_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property at every edge, reset included
`define M3I_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/core/m3inv_pkg.sv
// Package for the 3x3 matrix inverse: index types and the cofactor operand table.
// No dependencies.
package m3inv_pkg;

  // Width of the singular limit register
  localparam int LIMIT_WIDTH = 32;

  // Store index, nine entries
  typedef logic [3:0] m3_idx_t;

  // Cofactor k = m[i1]*m[i2] - m[i3]*m[i4], packed {i1,i2,i3,i4}, column-major store
  localparam logic [15:0] COF_SEL [9] = '{
    16'h4875, 16'h7218, 16'h1542, 16'h6538, 16'h0862,
    16'h3205, 16'h3764, 16'h6107, 16'h0431
  };

endpackage

FILE: rtl/core/matrix3x3_inverse.sv
// 3x3 matrix inverse by the adjugate method, signed fixed point.
// Depends on m3inv_pkg.
//
// Usage:
//   Input channel (in_valid / in_stall): nine elements in column-major order,
//   one per transfer. Result channel (out_valid / out_stall): nine inverse
//   elements in column-major order, out_last_element on the ninth. A matrix
//   whose determinant magnitude is below the limit gives nine zeros with
//   out_singular set.
//   Config channel (cfg_valid / cfg_ready): writes singular_limit, raw Q units;
//   write only while the block is idle. cfg_ready is always high.
// Operation:
//   Loading takes one element per cycle. After the ninth the block stalls its
//   input while it works: it forms the nine cofactors, then the three
//   determinant terms, then the determinant magnitude, and then each result
//   element in turn with the one-bit-a-cycle restoring divider. A singular
//   matrix skips the divide and gives its zero results directly. Elements and
//   cofactors sit in two memories with registered reads; one shared
//   multiplier forms all products. A stalled result holds in the output
//   register; the block waits in its emit step until the register frees, and
//   takes the next matrix while the last result still waits.
// Reset: input ready for the first element, no result pending, limit = 1.
module matrix3x3_inverse import m3inv_pkg::*; #(
  parameter int ELEMENT_WIDTH = 32,
  parameter int FRACTION_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic signed [ELEMENT_WIDTH-1:0] in_element_value,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic signed [ELEMENT_WIDTH-1:0] out_inverse_value,
  output logic                            out_singular,
  output logic                            out_last_element,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [LIMIT_WIDTH-1:0]          cfg_data
);

  localparam int W    = ELEMENT_WIDTH;
  localparam int F    = FRACTION_BITS;
  localparam int MW   = W + 1;
  localparam int PW   = 2 * W + 2;
  localparam int CW   = 2 * W + 1;
  localparam int DW   = 3 * W + 2;
  localparam int NW   = CW + 2 * F;
  localparam int LW   = LIMIT_WIDTH + 2 * F;
  localparam int SW   = (DW > LW) ? DW : LW;
  localparam int OW   = DW + W;
  localparam int CMPW = (NW > OW) ? NW : OW;
  localparam int BCW  = $clog2(W + 1);

  typedef enum logic [2:0] {
    S_LOAD, S_COF, S_DET, S_CHK, S_DIVRD, S_DIVSET, S_DIVIT, S_EMIT
  } state_t;

  state_t                 state_r;
  m3_idx_t                cnt_r;
  logic [2:0]             ph_r;
  logic [BCW-1:0]         bit_r;
  logic [LIMIT_WIDTH-1:0] limit_r;

  logic [W-1:0]           mat_mem [9];
  logic [CW-1:0]          cof_mem [9];
  logic [W-1:0]           mat_rd_r;
  logic [CW-1:0]          cof_rd_r;
  m3_idx_t                mat_addr;
  logic                   load_fire;
  logic                   cof_we;

  logic [W-1:0]           opa_r;
  logic signed [PW-1:0]   prod_r;
  logic signed [DW-1:0]   acc_r;
  logic [DW-1:0]          dabs_r;
  logic                   dneg_r;
  logic                   sing_r;
  logic                   qneg_r;
  logic                   ovf_r;
  logic [DW-1:0]          rem_r;
  logic [W-1:0]           nbits_r;
  logic [W-1:0]           quo_r;

  logic                   out_valid_r;
  logic [W-1:0]           out_value_r;
  logic                   out_sing_r;
  logic                   out_last_r;

  logic [15:0]            sel;
  logic signed [MW-1:0]   mul_a;
  logic signed [MW-1:0]   mul_b;
  logic [DW-1:0]          prod_ext;
  logic [CW-1:0]          cof_diff;
  logic                   sing_c;
  logic [CW-1:0]          cabs;
  logic [NW-1:0]          num;
  logic [CMPW-1:0]        num_w;
  logic [DW:0]            rem_shift;
  logic [DW:0]            rem_sub;
  logic                   rem_ge;
  logic [W-1:0]           sat_value;

  assign in_stall          = (state_r != S_LOAD);
  assign cfg_ready         = 1'b1;
  assign out_valid         = out_valid_r;
  assign out_inverse_value = out_value_r;
  assign out_singular      = out_sing_r;
  assign out_last_element  = out_last_r;

  assign load_fire = in_valid && !in_stall;
  assign cof_we    = (state_r == S_COF) && (ph_r == 3'd5);

  // Pick element read address from the cofactor table or the determinant row
  assign sel = COF_SEL[cnt_r];
  always_comb begin
    case (state_r)
      S_COF:   mat_addr = sel[{~ph_r[1:0], 2'b00} +: 4];
      S_DET:   mat_addr = cnt_r * 4'd3;
      default: mat_addr = '0;
    endcase
  end

  // Element memory: write on input transfer, registered read
  always_ff @(posedge clk) begin
    if (load_fire) begin
      mat_mem[cnt_r] <= in_element_value;
    end
    mat_rd_r <= mat_mem[mat_addr];
  end

  // Cofactor memory: write after each difference, registered read
  always_ff @(posedge clk) begin
    if (cof_we) begin
      cof_mem[cnt_r] <= cof_diff;
    end
    cof_rd_r <= cof_mem[cnt_r];
  end

  // Shared multiplier operands: element pairs, or element by cofactor half
  always_comb begin
    if (state_r == S_DET) begin
      mul_a = {mat_rd_r[W-1], mat_rd_r};
      mul_b = (ph_r == 3'd2) ? {1'b0, cof_rd_r[W-1:0]} : cof_rd_r[CW-1:W];
    end else begin
      mul_a = {opa_r[W-1], opa_r};
      mul_b = {mat_rd_r[W-1], mat_rd_r};
    end
  end

  assign prod_ext = {{(DW-PW){prod_r[PW-1]}}, prod_r};
  assign cof_diff = acc_r[CW-1:0] - prod_r[CW-1:0];

  // Singular test on the registered determinant magnitude
  assign sing_c = (dabs_r == '0) || (SW'(dabs_r) < (SW'(limit_r) << (2 * F)));

  // Divider setup: scaled numerator magnitude
  assign cabs  = cof_rd_r[CW-1] ? (~cof_rd_r + 1'b1) : cof_rd_r;
  assign num   = NW'(cabs) << (2 * F);
  assign num_w = CMPW'(num);

  // Restoring step: shift in next numerator bit, subtract when it fits
  assign rem_shift = {rem_r, nbits_r[W-1]};
  assign rem_sub   = rem_shift - {1'b0, dabs_r};
  assign rem_ge    = (rem_shift >= {1'b0, dabs_r});

  // Saturate the signed quotient
  always_comb begin
    if (qneg_r) begin
      if (ovf_r || (quo_r[W-1] && (|quo_r[W-2:0]))) begin
        sat_value = {1'b1, {(W-1){1'b0}}};
      end else begin
        sat_value = ~quo_r + 1'b1;
      end
    end else begin
      if (ovf_r || quo_r[W-1]) begin
        sat_value = {1'b0, {(W-1){1'b1}}};
      end else begin
        sat_value = quo_r;
      end
    end
  end

  // Multiplier output register
  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  // Sequencer, datapath registers and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      cnt_r       <= '0;
      ph_r        <= '0;
      bit_r       <= '0;
      limit_r     <= LIMIT_WIDTH'(1);
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        limit_r <= cfg_data;
      end
      // Drop the result once transferred; the emit step reloads it itself
      if (!out_stall && (state_r != S_EMIT)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_LOAD: begin
          if (load_fire) begin
            if (cnt_r == 4'd8) begin
              cnt_r   <= '0;
              ph_r    <= '0;
              state_r <= S_COF;
            end else begin
              cnt_r <= cnt_r + 4'd1;
            end
          end
        end
        S_COF: begin
          case (ph_r)
            3'd1: opa_r <= mat_rd_r;
            3'd3: begin
              acc_r <= prod_ext;
              opa_r <= mat_rd_r;
            end
            default: ;
          endcase
          if (ph_r == 3'd5) begin
            ph_r <= '0;
            if (cnt_r == 4'd8) begin
              cnt_r   <= '0;
              acc_r   <= '0;
              state_r <= S_DET;
            end else begin
              cnt_r <= cnt_r + 4'd1;
            end
          end else begin
            ph_r <= ph_r + 3'd1;
          end
        end
        S_DET: begin
          if (ph_r == 3'd3) begin
            acc_r <= acc_r + prod_ext;
          end
          if (ph_r == 3'd4) begin
            acc_r <= acc_r + (prod_ext << W);
            ph_r  <= '0;
            if (cnt_r == 4'd2) begin
              state_r <= S_CHK;
            end else begin
              cnt_r <= cnt_r + 4'd1;
            end
          end else begin
            ph_r <= ph_r + 3'd1;
          end
        end
        S_CHK: begin
          dabs_r  <= acc_r[DW-1] ? (~acc_r + 1'b1) : acc_r;
          dneg_r  <= acc_r[DW-1];
          cnt_r   <= '0;
          state_r <= S_DIVRD;
        end
        S_DIVRD: begin
          sing_r  <= sing_c;
          state_r <= sing_c ? S_EMIT : S_DIVSET;
        end
        S_DIVSET: begin
          ovf_r   <= (num_w >= (CMPW'(dabs_r) << W));
          rem_r   <= DW'(num_w >> W);
          nbits_r <= num[W-1:0];
          qneg_r  <= cof_rd_r[CW-1] ^ dneg_r;
          quo_r   <= '0;
          bit_r   <= BCW'(W);
          state_r <= S_DIVIT;
        end
        S_DIVIT: begin
          rem_r   <= rem_ge ? rem_sub[DW-1:0] : rem_shift[DW-1:0];
          quo_r   <= {quo_r[W-2:0], rem_ge};
          nbits_r <= {nbits_r[W-2:0], 1'b0};
          bit_r   <= bit_r - 1'b1;
          if (bit_r == BCW'(1)) begin
            state_r <= S_EMIT;
          end
        end
        S_EMIT: begin
          // Load the output register once it is free or being taken
          if (!out_valid_r || !out_stall) begin
            out_valid_r <= 1'b1;
            out_value_r <= sing_r ? '0 : sat_value;
            out_sing_r  <= sing_r;
            out_last_r  <= (cnt_r == 4'd8);
            if (cnt_r == 4'd8) begin
              cnt_r   <= '0;
              state_r <= S_LOAD;
            end else begin
              cnt_r   <= cnt_r + 4'd1;
              state_r <= S_DIVRD;
            end
          end
        end
        default: state_r <= S_LOAD;
      endcase
    end
  end

endmodule

FILE: rtl/core/m3inv_chk.sv
// Port checker for the 3x3 matrix inverse, bound to the top level.
// Depends on matrix3x3_inverse_assert.svh.
`include "matrix3x3_inverse_assert.svh"
module m3inv_chk #(
  parameter int ELEMENT_WIDTH = 32
) (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_stall,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic signed [ELEMENT_WIDTH-1:0] out_inverse_value,
  input logic                            out_singular,
  input logic                            out_last_element
);

  // Hold a stalled result
  `M3I_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_inverse_value), "stalled result changed")

  // Zero value on a singular result
  `M3I_ASSERT(a_sing_zero, out_valid && out_singular |-> out_inverse_value == '0, "singular result not zero")

  // While loading, only the last result of a run may still wait
  `M3I_ASSERT(a_load_last, out_valid && !in_stall |-> out_last_element, "loading with run unfinished")

  // Reset empties the output
  `M3I_ASSERT_ALWAYS(a_rst_empty, !rst_n |=> !out_valid, "result valid after reset")

endmodule

bind matrix3x3_inverse m3inv_chk #(.ELEMENT_WIDTH(ELEMENT_WIDTH)) u_m3inv_chk (.*);
